@@ rtl/lpmt_pkg.sv @@
// ============================================================================
// lpmt_pkg
// Shared constants and helper functions for the longest prefix match trie.
// ============================================================================
package lpmt_pkg;

    localparam logic [31:0] TOP_BIT = 32'h8000_0000;
    localparam logic        KIND_INSERT = 1'b0;
    localparam logic        KIND_LOOKUP = 1'b1;

    // Mask with the top len bits set; len saturates at 32.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len >= 6'd32) begin
            m = '1;
        end else begin
            m = ~(32'hFFFF_FFFF >> len[4:0]);
        end
        return m;
    endfunction

    // Branch bit below a node of length len; none at length 32.
    function automatic logic branch_right(input logic [31:0] v, input logic [5:0] len);
        logic r;
        if (len >= 6'd32) begin
            r = 1'b0;
        end else begin
            r = v[5'd31 - len[4:0]];
        end
        return r;
    endfunction

endpackage

@@ rtl/longest_prefix_match_trie.sv @@
// ============================================================================
// longest_prefix_match_trie
// IPv4 route table as a path-compressed binary trie in one node memory.
// ============================================================================
// channel  direction  fields
// in       input      kind, prefix, prefix_len, route_id, address
// out      output     found, best_route, full_res
//
// A lookup is accepted in S_IDLE, then visits each trie level in three steps
// (read, wait, compare) and takes one more step when the walk runs off an empty
// link; an insert adds node and parent link writes (S_WR1, S_WR2, S_PRD, S_PWR).
// The single port node memory with its registered read sets this.
// Reset empties the tree at once; no clearing pass. One item at a time; a new
// word is taken only when the output register is empty or drains that cycle.
module longest_prefix_match_trie #(
    parameter int NODES  = 1024,
    parameter int ROUTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_prefix,
    input  logic [5:0]  i_prefix_len,
    input  logic [8:0]  i_route_id,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [8:0]  o_best_route,
    output logic        o_full_res
);
    import lpmt_pkg::*;

    localparam int AW = $clog2(NODES);
    localparam int NW = $clog2(NODES + 1);
    localparam int RW = $clog2(ROUTES);
    localparam int EW = 32 + 6 + 1 + RW + 2 * NW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_WR1  = 3'd4;
    localparam logic [2:0] S_WR2  = 3'd5;
    localparam logic [2:0] S_PRD  = 3'd6;
    localparam logic [2:0] S_PWR  = 3'd7;

    typedef struct packed {
        logic [31:0]   label;
        logic [5:0]    len;
        logic          rvalid;
        logic [RW-1:0] route;
        logic [NW-1:0] right;
        logic [NW-1:0] left;
    } t_node;

    logic [2:0]    r_state, n_state;
    logic [NW-1:0] r_used, n_used;
    logic [NW-1:0] r_root, n_root;
    logic          r_kind;
    logic [31:0]   r_key;
    logic [5:0]    r_plen;
    logic [RW-1:0] r_rid;
    logic [NW-1:0] r_cur, n_cur;
    logic [NW-1:0] r_parent, n_parent;
    logic          r_side, n_side;
    logic          r_best_v, n_best_v;
    logic [RW-1:0] r_best, n_best;
    t_node         r_cn, n_cn;          // node under evaluation
    t_node         r_w2, n_w2;          // second node to write
    logic [NW-1:0] r_w2n, n_w2n;
    logic [NW-1:0] r_made, n_made;
    logic          r_has2, n_has2;
    logic          r_ov, n_ov;
    logic          r_of, n_of, r_ofull, n_ofull;
    logic [8:0]    r_orte, n_orte;

    logic          m_we;
    logic [AW-1:0] m_addr;
    t_node         m_wd, m_rd;

    lpmt_ram #(.WIDTH(EW), .DEPTH(NODES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_addr (m_addr),
        .i_wdata(m_wd),
        .o_rdata(m_rd)
    );

    logic          acc_in, busy_done;
    logic [5:0]    lead, c;
    logic [31:0]   x;
    logic          old_r;

    assign o_ready = (r_state == S_IDLE) && (!r_ov || i_ready);
    assign acc_in  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_found = r_of;
    assign o_best_route = r_orte;
    assign o_full_res = r_ofull;

    // Leading equal bits between stored label and key
    always_comb begin
        x = m_rd.label ^ r_key;
        lead = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) lead = 6'(31 - i);
        end
        c = lead;
        if (c > m_rd.len) c = m_rd.len;
        if (c > r_plen)   c = r_plen;
        old_r = branch_right(m_rd.label, c);
    end

    // Sequencer
    always_comb begin
        n_state = r_state; n_used = r_used; n_root = r_root;
        n_cur = r_cur; n_parent = r_parent; n_side = r_side;
        n_best_v = r_best_v; n_best = r_best; n_cn = r_cn;
        n_w2 = r_w2; n_w2n = r_w2n; n_made = r_made; n_has2 = r_has2;
        n_ov = r_ov; n_of = r_of; n_ofull = r_ofull; n_orte = r_orte;
        m_we = 1'b0; m_addr = r_cur[AW-1:0] - AW'(1); m_wd = r_cn;
        busy_done = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_cur = r_root; n_parent = '0; n_side = 1'b0;
                    n_best_v = 1'b0; n_best = '0;
                    if (i_kind == KIND_INSERT &&
                        (NW'(NODES) - r_used) < NW'(2)) begin
                        n_ov = 1'b1; n_of = 1'b0; n_ofull = 1'b1; n_orte = '0;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (r_cur == '0) begin
                    if (r_kind == KIND_LOOKUP) begin
                        busy_done = 1'b1;
                    end else begin
                        // Attach new leaf
                        n_made = r_used + NW'(1);
                        n_used = r_used + NW'(1);
                        n_cn = '{r_key, r_plen, 1'b1, r_rid, '0, '0};
                        n_has2 = 1'b0;
                        n_state = S_WR1;
                    end
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (r_kind == KIND_LOOKUP) begin
                    if ((r_key & len_mask(m_rd.len)) != m_rd.label) begin
                        busy_done = 1'b1;
                    end else begin
                        if (m_rd.rvalid) begin
                            n_best_v = 1'b1; n_best = m_rd.route;
                        end
                        if (m_rd.len >= 6'd32) begin
                            busy_done = 1'b1;
                            n_best_v = m_rd.rvalid ? 1'b1 : r_best_v;
                        end else begin
                            n_cur = branch_right(r_key, m_rd.len) ? m_rd.right : m_rd.left;
                            n_state = S_READ;
                        end
                    end
                end else if (c < m_rd.len) begin
                    // Split: new inner node above the current one
                    n_made = r_used + NW'(1);
                    n_cn.label = m_rd.label & len_mask(c);
                    n_cn.len = c;
                    n_cn.rvalid = (c == r_plen);
                    n_cn.route = (c == r_plen) ? r_rid : '0;
                    n_w2 = '{r_key, r_plen, 1'b1, r_rid, '0, '0};
                    n_w2n = r_used + NW'(2);
                    n_has2 = (c != r_plen);
                    n_cn.right = old_r ? r_cur : ((c != r_plen) ? n_w2n : '0);
                    n_cn.left  = old_r ? ((c != r_plen) ? n_w2n : '0) : r_cur;
                    n_used = r_used + ((c != r_plen) ? NW'(2) : NW'(1));
                    n_state = S_WR1;
                end else if (r_plen == m_rd.len) begin
                    if (!m_rd.rvalid) begin
                        n_cn = m_rd; n_cn.rvalid = 1'b1; n_cn.route = r_rid;
                        n_made = '0; n_has2 = 1'b0;
                        n_state = S_WR1;
                    end else begin
                        busy_done = 1'b1;
                    end
                end else begin
                    n_parent = r_cur;
                    n_side = branch_right(r_key, m_rd.len);
                    n_cur = n_side ? m_rd.right : m_rd.left;
                    n_state = S_READ;
                end
            end
            S_WR1: begin
                m_we = 1'b1;
                m_addr = (r_made == '0) ? (r_cur[AW-1:0] - AW'(1))
                                        : (r_made[AW-1:0] - AW'(1));
                m_wd = r_cn;
                n_state = r_has2 ? S_WR2 : S_PRD;
                if (r_made == '0) busy_done = 1'b1;
            end
            S_WR2: begin
                m_we = 1'b1; m_addr = r_w2n[AW-1:0] - AW'(1); m_wd = r_w2;
                n_state = S_PRD;
            end
            S_PRD: begin
                if (r_parent == '0) begin
                    n_root = r_made; busy_done = 1'b1;
                end else begin
                    m_addr = r_parent[AW-1:0] - AW'(1);
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                // Parent link rewrite, with the parent read issued in S_PRD
                m_we = 1'b1; m_addr = r_parent[AW-1:0] - AW'(1);
                m_wd = m_rd;
                if (r_side) m_wd.right = r_made; else m_wd.left = r_made;
                busy_done = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
        if (busy_done) begin
            n_state = S_IDLE; n_ov = 1'b1; n_ofull = 1'b0;
            n_of = (r_kind == KIND_LOOKUP) && n_best_v;
            n_orte = n_of ? 9'(n_best) : '0;
        end
    end

    // State and node count registers; S_PRD issues the parent read that S_PWR uses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_root <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_root <= n_root; r_ov <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_kind <= i_kind;
            r_plen <= (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;
            r_key  <= (i_kind == KIND_INSERT)
                      ? (i_prefix & len_mask(i_prefix_len)) : i_address;
            r_rid  <= i_route_id[RW-1:0];
        end
        r_cur <= n_cur; r_parent <= n_parent; r_side <= n_side;
        r_best_v <= n_best_v; r_best <= n_best; r_cn <= n_cn;
        r_w2 <= n_w2; r_w2n <= n_w2n; r_made <= n_made; r_has2 <= n_has2;
        r_of <= n_of; r_ofull <= n_ofull; r_orte <= n_orte;
    end

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NW'(NODES)) else $error("node count overflow");
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root <= r_used) else $error("root beyond allocated nodes");
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_of && r_ofull)) else $error("found and full together");
`endif
endmodule

@@ rtl/lpmt_ram.sv @@
// ============================================================================
// lpmt_ram
// Generic single port RAM with registered read data.
// ============================================================================
module lpmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write when enabled; read data is registered on every clock (old data on a write)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ tb/sv/longest_prefix_match_trie_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// longest_prefix_match_trie_tb
// Drives route inserts and address lookups into the trie and checks each
// result word against a behavioral route table kept in the testbench.
// ============================================================================
module longest_prefix_match_trie_tb;
    import lpmt_pkg::*;

    localparam int NODES    = 1024;
    localparam int ROUTES   = 512;
    localparam int DOG_MAX  = 20000;
    localparam int N_RANDOM = 1080;
    localparam int POOL_SZ  = 48;

    typedef struct packed {
        logic       found;
        logic [8:0] best_route;
        logic       full_res;
    } route_res_t;

    typedef struct {
        logic        kind;
        logic [31:0] prefix;
        logic [5:0]  plen;
        logic [8:0]  rid;
        logic [31:0] addr;
        logic        has_exp;
        route_res_t  exp_res;
    } route_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_kind = KIND_LOOKUP;
    logic [31:0] i_prefix = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [8:0]  i_route_id = '0;
    logic [31:0] i_address = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [8:0]  o_best_route;
    logic        o_full_res;

    longest_prefix_match_trie #(.NODES(NODES), .ROUTES(ROUTES)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Route table mirror: nodes numbered from 1, 0 means none.
    logic [31:0] tr_label [1:NODES];
    logic [5:0]  tr_len   [1:NODES];
    logic        tr_has   [1:NODES];
    logic [8:0]  tr_rid   [1:NODES];
    int          tr_left  [1:NODES];
    int          tr_right [1:NODES];
    int          tr_used;
    int          tr_root;

    route_res_t  pending_res[$];
    route_row_t  dir_rows[$];
    logic [31:0] route_pool[$];
    int          errors = 0;
    int          n_ins = 0, n_look = 0, n_full = 0, n_hit = 0, n_res = 0;
    int          send_idle = 9, recv_idle = 65;

    function automatic logic [31:0] mask_of(int len);
        return (len == 0) ? 32'h0 : ((len >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> len));
    endfunction

    function automatic logic go_right(logic [31:0] v, int len);
        return (len < 32) && v[31 - len];
    endfunction

    function automatic int lead_agree(logic [31:0] a, logic [31:0] b);
        int n;
        logic [31:0] x;
        x = a ^ b;
        n = 0;
        while (n < 32 && !x[31 - n]) n++;
        return n;
    endfunction

    function automatic int new_node(logic [31:0] lab, int len, logic has, logic [8:0] rid);
        tr_used++;
        tr_label[tr_used] = lab;
        tr_len[tr_used]   = 6'(len);
        tr_has[tr_used]   = has;
        tr_rid[tr_used]   = rid;
        tr_left[tr_used]  = 0;
        tr_right[tr_used] = 0;
        return tr_used;
    endfunction

    function automatic void link(int n, logic right, int c);
        if (right) tr_right[n] = c;
        else tr_left[n] = c;
    endfunction

    // Insert a route; returns 1 when refused for lack of room.
    function automatic logic route_insert(logic [31:0] pfx, int plen, logic [8:0] rid);
        int cur, par, c, tl, made, leaf;
        logic side, old_r;
        if (NODES - tr_used < 2) return 1'b1;
        if (plen > 32) plen = 32;
        pfx &= mask_of(plen);
        cur = tr_root;
        par = 0;
        side = 1'b0;
        for (int s = 0; s < 40; s++) begin
            if (cur == 0) begin
                made = new_node(pfx, plen, 1'b1, rid);
            end else begin
                tl = tr_len[cur];
                c = lead_agree(tr_label[cur], pfx);
                if (c > tl) c = tl;
                if (c > plen) c = plen;
                if (c < tl) begin
                    old_r = go_right(tr_label[cur], c);
                    made = new_node(tr_label[cur] & mask_of(c), c, 1'b0, '0);
                    link(made, old_r, cur);
                    if (c == plen) begin
                        tr_has[made] = 1'b1;
                        tr_rid[made] = rid;
                    end else begin
                        leaf = new_node(pfx, plen, 1'b1, rid);
                        link(made, !old_r, leaf);
                    end
                end else if (plen == tl) begin
                    // Duplicate prefix: keep the first route id
                    if (!tr_has[cur]) begin
                        tr_has[cur] = 1'b1;
                        tr_rid[cur] = rid;
                    end
                    return 1'b0;
                end else begin
                    par = cur;
                    side = go_right(pfx, tl);
                    cur = side ? tr_right[cur] : tr_left[cur];
                    continue;
                end
            end
            if (par == 0) tr_root = made;
            else link(par, side, made);
            return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic route_res_t route_predict(route_row_t w);
        route_res_t r;
        int cur, len;
        r = '0;
        if (w.kind == KIND_INSERT) begin
            r.full_res = route_insert(w.prefix, w.plen, w.rid);
        end else begin
            cur = tr_root;
            for (int s = 0; s < 40 && cur != 0; s++) begin
                len = tr_len[cur];
                if ((w.addr & mask_of(len)) != tr_label[cur]) break;
                if (tr_has[cur]) begin
                    r.found = 1'b1;
                    r.best_route = tr_rid[cur];
                end
                if (len >= 32) break;
                cur = go_right(w.addr, len) ? tr_right[cur] : tr_left[cur];
            end
        end
        return r;
    endfunction

    // Drive one word and wait for acceptance; predictor runs on acceptance.
    task automatic send_word(route_row_t w);
        route_res_t p;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= w.kind;
        i_prefix     <= w.prefix;
        i_prefix_len <= w.plen;
        i_route_id   <= w.rid;
        i_address    <= w.addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = route_predict(w);
        if (w.has_exp && p != w.exp_res) begin
            $display("%0t: table row disagrees: row %h predictor %h", $time, w.exp_res, p);
            errors++;
        end
        pending_res.push_back(p);
        if (w.kind == KIND_INSERT) begin
            n_ins++;
            n_full += p.full_res;
        end else begin
            n_look++;
            n_hit += p.found;
        end
        @(negedge i_clk);
    endtask

    function automatic route_row_t mk(logic k, logic [31:0] pf, logic [5:0] pl,
                                      logic [8:0] ri, logic [31:0] ad,
                                      logic he = 1'b0, route_res_t ex = '0);
        route_row_t w;
        w.kind = k; w.prefix = pf; w.plen = pl; w.rid = ri; w.addr = ad;
        w.has_exp = he; w.exp_res = ex;
        return w;
    endfunction

    // Random word: inserts and lookups at even odds, mostly near known prefixes
    function automatic route_row_t rand_word();
        route_row_t w;
        logic [31:0] base;
        w = mk(KIND_INSERT, $urandom, 6'($urandom_range(0, 32)), 9'($urandom), $urandom);
        if ($urandom_range(9) == 0) w.plen = 6'($urandom_range(33, 63));
        if (route_pool.size() > 0 && $urandom_range(3) != 0) begin
            base = route_pool[$urandom_range(route_pool.size() - 1)];
            w.prefix = base ^ ($urandom >> $urandom_range(0, 31));
            w.addr   = base ^ ($urandom >> $urandom_range(0, 32));
        end
        w.kind = ($urandom_range(1) == 0) ? KIND_INSERT : KIND_LOOKUP;
        if (w.kind == KIND_INSERT && route_pool.size() < POOL_SZ) route_pool.push_back(w.prefix);
        return w;
    endfunction

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        route_res_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_found, o_best_route, o_full_res};
            n_res++;
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (got.found !== want.found)
                    $display("%0t: found expected %b actual %b", $time, want.found, got.found);
                if (got.best_route !== want.best_route)
                    $display("%0t: best_route expected %0d actual %0d", $time,
                             want.best_route, got.best_route);
                if (got.full_res !== want.full_res)
                    $display("%0t: full_res expected %b actual %b", $time,
                             want.full_res, got.full_res);
                if (got !== want) errors++;
            end
        end
    end

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle);

    // Watchdog on cycles without any handshake
    int dog = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) dog <= 0;
        else dog <= dog + 1;
        if (dog >= DOG_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        route_row_t w;
        tr_used = 0;
        tr_root = 0;
        // Directed table: empty tree, extremes, duplicate, host routes, bit 31
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h0, 1'b1, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF, 1'b1, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'h0A00_0000, 6'd8, 9'd10, '0, 1'b1, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h0A01_0203, 1'b1, '{1'b1, 9'd10, 1'b0}));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h0B00_0000, 1'b1, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'h0AFF_FFFF, 6'd8, 9'd99, '0, 1'b1, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h0A00_0000, 1'b1, '{1'b1, 9'd10, 1'b0}));
        dir_rows.push_back(mk(KIND_INSERT, 32'hFFFF_FFFF, 6'd0, 9'd511, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h8000_0000));
        dir_rows.push_back(mk(KIND_INSERT, 32'h8000_0000, 6'd1, 9'd1, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'h0000_0000, 6'd1, 9'd2, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'hC0A8_0101, 6'd32, 9'd300, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'hC0A8_0101, 6'd63, 9'd301, '0));
        dir_rows.push_back(mk(KIND_INSERT, 32'hC0A8_0100, 6'd33, 9'd302, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'hC0A8_0101));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'hC0A8_0100));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'hC0A8_0102));
        dir_rows.push_back(mk(KIND_INSERT, 32'hC0A8_0000, 6'd16, 9'd16, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'hC0A8_FFFF));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h0000_0000));
        dir_rows.push_back(mk(KIND_INSERT, 32'h5555_5555, 6'd31, 9'h155, '0));
        dir_rows.push_back(mk(KIND_LOOKUP, '0, '0, '0, 32'h5555_5554));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i]);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 9 : ((ph == 1) ? 65 : 0);
            recv_idle = (ph == 0) ? 65 : ((ph == 1) ? 9 : 0);
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                w = rand_word();
                send_word(w);
            end
        end
        // Fill the memory until inserts are refused, then probe it
        while (tr_used < NODES - 1) begin
            w = rand_word();
            w.kind = KIND_INSERT;
            send_word(w);
        end
        for (int i = 0; i < 20; i++) begin
            w = rand_word();
            send_word(w);
        end
        i_valid <= 1'b0;

        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d inserts (%0d refused, %0d nodes) and %0d lookups (%0d hits)",
                 n_ins, n_full, tr_used, n_look, n_hit);
        $display("%0d result words checked, %0d mismatches", n_res, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ longest_prefix_match_trie.f @@
rtl/lpmt_pkg.sv
rtl/lpmt_ram.sv
rtl/longest_prefix_match_trie.sv
tb/sv/longest_prefix_match_trie_tb.sv
